// ===== rtl/kdpc_pkg.sv =====
package kdpc_pkg;

    localparam int NUM_KEYS = 12;

    localparam int KEY_W   = 12;
    localparam int TICK_W  = 8;
    localparam int LONG_W  = 10;
    localparam int COUNT_W = 4;
    localparam int EVENT_W = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;

    typedef logic [EVENT_W-1:0]   t_event;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_event EV_NONE     = 3'd0;
    localparam t_event EV_DOWN     = 3'd1;
    localparam t_event EV_SHORT_UP = 3'd2;
    localparam t_event EV_LONG     = 3'd3;
    localparam t_event EV_LONG_UP  = 3'd4;

    localparam t_cfg_idx CFG_DEBOUNCE_TICKS = 4'd0;
    localparam t_cfg_idx CFG_LONG_CHECKS    = 4'd1;
    localparam t_cfg_idx CFG_KEY_COUNT      = 4'd2;
    localparam t_cfg_idx CFG_RELEASE_MODE   = 4'd3;

endpackage

// ===== rtl/key_debounce_press_classifier.sv =====
// Key debounce and press classifier. Each request on the input channel is one timer tick
// carrying the raw active-low key pins; every tick yields exactly one result, which sits
// in a single output register from the cycle after the tick. A new tick is taken in
// every cycle, also while the previous result is being handed over; the input stalls only
// while a result waits in the output register and the output side stalls. The sampling
// prescaler, the four-phase press machine and the long-press counter all update in the
// cycle that takes a tick; when unstalled, one tick per clock. Configuration writes take
// effect on the next tick; writes to indexes above the four registers are ignored.
module key_debounce_press_classifier
    import kdpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [KEY_W-1:0]      i_pin_levels,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [EVENT_W-1:0]    o_event_code,
    output logic [KEY_W-1:0]      o_key_mask,
    output logic [KEY_W-1:0]      o_press_fire_mask,
    output logic [KEY_W-1:0]      o_release_fire_mask
);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_CONFIRM = 2'd1,
        PH_HELD    = 2'd2,
        PH_LONG    = 2'd3
    } t_phase;

    // configuration
    logic [TICK_W-1:0]  r_debounce_ticks;
    logic [LONG_W-1:0]  r_long_checks;
    logic [COUNT_W-1:0] r_key_count;
    logic [KEY_W-1:0]   r_release_mode;

    // press state
    logic [TICK_W-1:0]  r_tick_count, n_tick_count;
    t_phase             r_phase, n_phase;
    logic [KEY_W-1:0]   r_held_mask, n_held_mask;
    logic [LONG_W-1:0]  r_long_count, n_long_count;

    // result register
    logic               r_out_valid;
    t_event             r_event_code, n_event_code;
    logic [KEY_W-1:0]   r_key_mask, n_key_mask;
    logic [KEY_W-1:0]   r_press_fire, n_press_fire;
    logic [KEY_W-1:0]   r_release_fire, n_release_fire;

    logic               w_accept;
    logic               w_sample;
    logic [TICK_W-1:0]  w_tick_inc;
    logic [LONG_W-1:0]  w_long_inc;
    logic [COUNT_W-1:0] w_keys_used;
    logic [KEY_W-1:0]   w_active;
    logic [KEY_W-1:0]   w_pressed;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_tick_inc = r_tick_count + TICK_W'(1);
    assign w_sample   = (w_tick_inc >= r_debounce_ticks);
    assign w_long_inc = r_long_count + LONG_W'(1);

    // key count saturates at the number of keys present
    assign w_keys_used = (r_key_count > COUNT_W'(NUM_KEYS)) ? COUNT_W'(NUM_KEYS) : r_key_count;

    always_comb begin
        for (int i = 0; i < KEY_W; i++) begin
            w_active[i] = (COUNT_W'(i) < w_keys_used) && (i < NUM_KEYS);
        end
    end

    assign w_pressed = ~i_pin_levels & w_active;

    always_comb begin
        n_tick_count = w_sample ? '0 : w_tick_inc;
        n_phase      = r_phase;
        n_held_mask  = r_held_mask;
        n_long_count = r_long_count;
        n_event_code = EV_NONE;
        n_key_mask   = '0;

        if (w_sample) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (w_pressed != '0) begin
                        n_held_mask = w_pressed;
                        n_phase     = PH_CONFIRM;
                    end
                end
                PH_CONFIRM: begin
                    if (w_pressed == r_held_mask) begin
                        n_phase      = PH_HELD;
                        n_event_code = EV_DOWN;
                        n_key_mask   = r_held_mask;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_HELD: begin
                    if (w_pressed != r_held_mask) begin
                        n_phase      = PH_IDLE;
                        n_long_count = '0;
                        n_event_code = EV_SHORT_UP;
                        n_key_mask   = r_held_mask;
                    end else if (w_long_inc >= r_long_checks) begin
                        n_long_count = '0;
                        n_phase      = PH_LONG;
                        n_event_code = EV_LONG;
                        n_key_mask   = w_pressed;
                    end else begin
                        n_long_count = w_long_inc;
                    end
                end
                PH_LONG: begin
                    if (w_pressed != r_held_mask) begin
                        n_phase      = PH_IDLE;
                        n_event_code = EV_LONG_UP;
                        n_key_mask   = r_held_mask;
                    end
                end
            endcase
        end
    end

    // callback masks follow the per-key release mode; a short release fires for every released key
    always_comb begin
        n_press_fire   = '0;
        n_release_fire = '0;
        unique case (n_event_code)
            EV_DOWN:     n_press_fire   = n_key_mask & r_release_mode;
            EV_SHORT_UP: n_release_fire = n_key_mask;
            EV_LONG:     n_press_fire   = n_key_mask & ~r_release_mode;
            EV_LONG_UP:  n_release_fire = n_key_mask & r_release_mode;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= TICK_W'(3);
            r_long_checks    <= LONG_W'(100);
            r_key_count      <= COUNT_W'(12);
            r_release_mode   <= '0;
            r_tick_count     <= '0;
            r_phase          <= PH_IDLE;
            r_held_mask      <= '0;
            r_long_count     <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_DEBOUNCE_TICKS: r_debounce_ticks <= i_cfg_data[TICK_W-1:0];
                    CFG_LONG_CHECKS:    r_long_checks    <= i_cfg_data[LONG_W-1:0];
                    CFG_KEY_COUNT:      r_key_count      <= i_cfg_data[COUNT_W-1:0];
                    CFG_RELEASE_MODE:   r_release_mode   <= i_cfg_data[KEY_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                r_tick_count <= n_tick_count;
                r_phase      <= n_phase;
                r_held_mask  <= n_held_mask;
                r_long_count <= n_long_count;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_event_code   <= n_event_code;
            r_key_mask     <= n_key_mask;
            r_press_fire   <= n_press_fire;
            r_release_fire <= n_release_fire;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_event_code        = r_event_code;
    assign o_key_mask          = r_key_mask;
    assign o_press_fire_mask   = r_press_fire;
    assign o_release_fire_mask = r_release_fire;

    // long counter only runs while held
    a_long_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_HELD |-> r_long_count == '0)
        else $error("long counter not clear outside held phase");

    a_held_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_IDLE |-> r_held_mask != '0)
        else $error("active phase with empty held mask");

    a_no_sample_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_sample |=> o_out_valid && o_event_code == EV_NONE)
        else $error("event reported on a tick without a sample");

    a_none_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_code == EV_NONE |->
            o_key_mask == '0 && o_press_fire_mask == '0 && o_release_fire_mask == '0)
        else $error("masks set without an event");

    a_release_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_release_fire_mask != '0 |->
            o_event_code == EV_SHORT_UP || o_event_code == EV_LONG_UP)
        else $error("release callback on a non-release event");

endmodule
